// ===== rtl/bmp_pkg.sv =====
// Shared constants and prime table for the binomial modulo prime unit.
package bmp_pkg;

    localparam int unsigned VAL_W = 10;
    localparam int unsigned RES_W = 30;
    localparam int unsigned EXP_W = 4;
    localparam int unsigned NUM_PRIMES = 172;
    localparam int unsigned IDX_W = $clog2(NUM_PRIMES);
    localparam int unsigned RCP_SHIFT = 20;
    localparam int unsigned RCP_W = 20;
    localparam int unsigned MAX_ARGUMENT = 1023;
    localparam logic [31:0] MODULUS = 32'd1000000007;
    localparam logic [31:0] MODULUS_X2 = 32'd2000000014;

    localparam int unsigned PRIME_TAB [NUM_PRIMES] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
        73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151,
        157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227, 229, 233,
        239, 241, 251, 257, 263, 269, 271, 277, 281, 283, 293, 307, 311, 313, 317,
        331, 337, 347, 349, 353, 359, 367, 373, 379, 383, 389, 397, 401, 409, 419,
        421, 431, 433, 439, 443, 449, 457, 461, 463, 467, 479, 487, 491, 499, 503,
        509, 521, 523, 541, 547, 557, 563, 569, 571, 577, 587, 593, 599, 601, 607,
        613, 617, 619, 631, 641, 643, 647, 653, 659, 661, 673, 677, 683, 691, 701,
        709, 719, 727, 733, 739, 743, 751, 757, 761, 769, 773, 787, 797, 809, 811,
        821, 823, 827, 829, 839, 853, 857, 859, 863, 877, 881, 883, 887, 907, 911,
        919, 929, 937, 941, 947, 953, 967, 971, 977, 983, 991, 997, 1009, 1013,
        1019, 1021
    };

endpackage

// ===== rtl/bmp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bmp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bmp_legendre.sv =====
// Iterative exponent of one table prime in C(n,k), by counting borrows digit by digit.
module bmp_legendre
    import bmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] idx,
    input  logic [VAL_W-1:0] n_val,
    input  logic [VAL_W-1:0] k_val,
    output logic             done,
    output logic [EXP_W-1:0] expo
);

    localparam int unsigned PROD_W = VAL_W + RCP_W;

    logic [RCP_W-1:0] recip_tab [NUM_PRIMES];

    for (genvar g = 0; g < NUM_PRIMES; g++)
    begin : g_rcp
        localparam int unsigned Rcp = (32'd1 << RCP_SHIFT) / PRIME_TAB[g] + 1;
        assign recip_tab[g] = RCP_W'(Rcp);
    end

    logic              busy_reg, busy_next;
    logic              mul_reg, mul_next;
    logic              done_reg, done_next;
    logic [VAL_W-1:0]  a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [PROD_W-1:0] pa_reg, pb_reg, pc_reg;
    logic [RCP_W-1:0]  recip_reg, recip_next;
    logic [EXP_W-1:0]  expo_reg, expo_next;
    logic [VAL_W-1:0]  qa, qb, qc, diff;

    assign qa = pa_reg[PROD_W-1:RCP_SHIFT];
    assign qb = pb_reg[PROD_W-1:RCP_SHIFT];
    assign qc = pc_reg[PROD_W-1:RCP_SHIFT];
    assign diff = qa - qb - qc;

    always_comb
    begin
        busy_next  = busy_reg;
        mul_next   = mul_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        recip_next = recip_reg;
        expo_next  = expo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            mul_next   = 1'b1;
            a_next     = n_val;
            b_next     = k_val;
            c_next     = n_val - k_val;
            recip_next = recip_tab[idx];
            expo_next  = '0;
        end
        else if (busy_reg && mul_reg)
        begin
            mul_next = 1'b0;
        end
        else if (busy_reg)
        begin
            expo_next = expo_reg + EXP_W'(diff[0]);
            a_next    = qa;
            b_next    = qb;
            c_next    = qc;
            mul_next  = 1'b1;
            if (qa == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        recip_reg <= recip_next;
        expo_reg  <= expo_next;
        pa_reg    <= PROD_W'(a_reg) * PROD_W'(recip_reg);
        pb_reg    <= PROD_W'(b_reg) * PROD_W'(recip_reg);
        pc_reg    <= PROD_W'(c_reg) * PROD_W'(recip_reg);
    end

    assign done = done_reg;
    assign expo = expo_reg;

endmodule

// ===== rtl/bmp_modmul.sv =====
// Bit-serial multiplier of a residue by a small prime, reduced modulo the modulus.
module bmp_modmul
    import bmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RES_W-1:0] mcand,
    input  logic [VAL_W-1:0] mplier,
    output logic             done,
    output logic [RES_W-1:0] prod
);

    localparam int unsigned CNT_W = $clog2(VAL_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0] mcand_reg, mcand_next;
    logic [VAL_W-1:0] mplier_reg, mplier_next;
    logic [RES_W-1:0] acc_reg, acc_next;
    logic [31:0]      sum;
    logic [31:0]      red;

    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0}
            + (mplier_reg[VAL_W-1] ? {2'b0, mcand_reg} : 32'd0);
        priority if (sum >= MODULUS_X2)
        begin
            red = sum - MODULUS_X2;
        end
        else if (sum >= MODULUS)
        begin
            red = sum - MODULUS;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = CNT_W'(VAL_W - 1);
            mcand_next  = mcand;
            mplier_next = mplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            acc_next    = red[RES_W-1:0];
            mplier_next = {mplier_reg[VAL_W-2:0], 1'b0};
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/binomial_mod_prime_unit.sv =====
// Top level of the binomial coefficient modulo 1000000007 unit.
//
// Input channel: n_total and k_chosen, taken with in_valid and in_ready.
// Output channel: binomial_value and invalid_args, given with out_valid and
// out_ready. One result transaction follows every input transaction.
// k above n (or n above the argument limit) gives invalid_args 1, value 0,
// and the unit goes straight from acceptance to its done state.
// Otherwise the first pass computes, for each of the 172 primes below 1024,
// its exponent in C(n,k) by digit-wise division and writes it to the exponent
// RAM. The second pass reads each exponent back and multiplies the running
// result by the prime that many times in a bit-serial modular multiplier.
// in_ready is high only while idle. A finished result waits in the output
// register while the receiver stalls; the next transaction may be taken
// meanwhile and its result is held until the register frees.
// Reset clears all control state and leaves the output channel empty.
module binomial_mod_prime_unit
    import bmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [VAL_W-1:0] n_total,
    input  logic [VAL_W-1:0] k_chosen,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [RES_W-1:0] binomial_value,
    output logic             invalid_args
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXP_GO   = 3'd1;
    localparam logic [2:0] S_EXP_WAIT = 3'd2;
    localparam logic [2:0] S_RD       = 3'd3;
    localparam logic [2:0] S_RD_WAIT  = 3'd4;
    localparam logic [2:0] S_POW      = 3'd5;
    localparam logic [2:0] S_MUL_WAIT = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PRIMES - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [VAL_W-1:0] n_reg, n_next, k_reg, k_next;
    logic [EXP_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0] r_reg, r_next;
    logic             inv_reg, inv_next;
    logic             out_valid_reg, out_valid_next;
    logic [RES_W-1:0] out_val_reg, out_val_next;
    logic             out_inv_reg, out_inv_next;

    logic             leg_start, leg_done;
    logic [EXP_W-1:0] leg_expo;
    logic             mm_start, mm_done;
    logic [RES_W-1:0] mm_prod;
    logic             ram_we;
    logic [EXP_W-1:0] ram_rdata;
    logic [VAL_W-1:0] prime_cur;
    logic             bad_args;

    assign prime_cur = VAL_W'(PRIME_TAB[idx_reg]);
    assign bad_args  = (k_chosen > n_total) || (32'(n_total) > 32'(MAX_ARGUMENT));
    assign in_ready  = (state_reg == S_IDLE);

    bmp_legendre u_legendre (
        .clk   (clk),
        .rst_n (rst_n),
        .start (leg_start),
        .idx   (idx_reg),
        .n_val (n_reg),
        .k_val (k_reg),
        .done  (leg_done),
        .expo  (leg_expo)
    );

    bmp_ram #(
        .WIDTH (EXP_W),
        .DEPTH (NUM_PRIMES)
    ) u_exp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (leg_expo),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    bmp_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .mcand  (r_reg),
        .mplier (prime_cur),
        .done   (mm_done),
        .prod   (mm_prod)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        inv_next       = inv_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_inv_next   = out_inv_reg;
        leg_start      = 1'b0;
        mm_start       = 1'b0;
        ram_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next   = n_total;
                    k_next   = k_chosen;
                    idx_next = '0;
                    if (bad_args)
                    begin
                        r_next     = '0;
                        inv_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        r_next     = RES_W'(1);
                        inv_next   = 1'b0;
                        state_next = S_EXP_GO;
                    end
                end
            end
            S_EXP_GO:
            begin
                leg_start  = 1'b1;
                state_next = S_EXP_WAIT;
            end
            S_EXP_WAIT:
            begin
                if (leg_done)
                begin
                    ram_we = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        state_next = S_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EXP_GO;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cnt_next   = ram_rdata;
                state_next = S_POW;
            end
            S_POW:
            begin
                if (cnt_reg == '0)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    mm_start   = 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_MUL_WAIT;
                end
            end
            S_MUL_WAIT:
            begin
                if (mm_done)
                begin
                    r_next     = mm_prod;
                    state_next = S_POW;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = r_reg;
                    out_inv_next   = inv_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        r_reg       <= r_next;
        inv_reg     <= inv_next;
        out_val_reg <= out_val_next;
        out_inv_reg <= out_inv_next;
    end

    assign out_valid      = out_valid_reg;
    assign binomial_value = out_val_reg;
    assign invalid_args   = out_inv_reg;

endmodule

// ===== tb/sv/binomial_mod_prime_unit_tb.sv =====
// Self-checking testbench for the binomial modulo prime unit: directed table, then random pairs.
module binomial_mod_prime_unit_tb;
    import bmp_pkg::*;

    localparam longint unsigned PRIME_MOD = 1000000007;
    localparam int N_DIRECTED = 18;
    localparam int N_RANDOM = 132;
    localparam longint CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic [VAL_W-1:0] n;
        logic [VAL_W-1:0] k;
        logic             known;
        logic [RES_W-1:0] value;
        logic             bad;
    } vector_t;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             bad;
    } binom_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [VAL_W-1:0] n_total;
    logic [VAL_W-1:0] k_chosen;
    logic             out_valid;
    logic             out_ready;
    logic [RES_W-1:0] binomial_value;
    logic             invalid_args;

    binom_t  pending_binoms[$];
    vector_t vectors[N_DIRECTED];
    binom_t  row_want;
    int      errors;
    longint  cycles;
    bit      rx_calm;
    bit      tx_calm;

    binomial_mod_prime_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .n_total        (n_total),
        .k_chosen       (k_chosen),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .binomial_value (binomial_value),
        .invalid_args   (invalid_args)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
        return (a * b) % PRIME_MOD;
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e);
        longint unsigned r;
        r = 1;
        b = b % PRIME_MOD;
        while (e != 0)
        begin
            if (e[0])
                r = mul_mod(r, b);
            b = mul_mod(b, b);
            e = e >> 1;
        end
        return r;
    endfunction

    // Multiplicative formula with a Fermat inverse of k!
    function automatic binom_t binom_mod(logic [VAL_W-1:0] n, logic [VAL_W-1:0] k);
        binom_t          res;
        longint unsigned num;
        longint unsigned den;
        int              i;
        num = 1;
        den = 1;
        if (k > n || n > MAX_ARGUMENT)
        begin
            res.value = '0;
            res.bad = 1'b1;
            return res;
        end
        for (i = 0; i < k; i++)
        begin
            num = mul_mod(num, n - i);
            den = mul_mod(den, i + 1);
        end
        res.value = RES_W'(mul_mod(num, pow_mod(den, PRIME_MOD - 2)));
        res.bad = 1'b0;
        return res;
    endfunction

    task automatic send_pair(logic [VAL_W-1:0] n, logic [VAL_W-1:0] k);
        while (!tx_calm && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        n_total <= n;
        k_chosen <= k;
        pending_binoms.push_back(binom_mod(n, k));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= rx_calm || ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        binom_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_binoms.size() == 0)
            begin
                $display("%0t: unexpected result value %0d invalid %0b", $time,
                         binomial_value, invalid_args);
                errors++;
            end
            else
            begin
                want = pending_binoms.pop_front();
                if (binomial_value !== want.value)
                begin
                    $display("%0t: binomial_value expected %0d actual %0d", $time,
                             want.value, binomial_value);
                    errors++;
                end
                if (invalid_args !== want.bad)
                begin
                    $display("%0t: invalid_args expected %0b actual %0b", $time,
                             want.bad, invalid_args);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        vectors = '{
            '{10'd0,    10'd0,    1'b1, 30'd1, 1'b0},
            '{10'd1023, 10'd0,    1'b1, 30'd1, 1'b0},
            '{10'd1023, 10'd1023, 1'b1, 30'd1, 1'b0},
            '{10'd1023, 10'd1,    1'b1, 30'd1023, 1'b0},
            '{10'd0,    10'd1,    1'b1, 30'd0, 1'b1},
            '{10'd0,    10'd1023, 1'b1, 30'd0, 1'b1},
            '{10'd1022, 10'd1023, 1'b1, 30'd0, 1'b1},
            '{10'd5,    10'd2,    1'b1, 30'd10, 1'b0},
            '{10'd1,    10'd1,    1'b1, 30'd1, 1'b0},
            '{10'd1023, 10'd511,  1'b0, '0, 1'b0},
            '{10'd1023, 10'd512,  1'b0, '0, 1'b0},
            '{10'd1000, 10'd500,  1'b0, '0, 1'b0},
            '{10'd1021, 10'd17,   1'b0, '0, 1'b0},
            '{10'd1009, 10'd3,    1'b0, '0, 1'b0},
            '{10'd997,  10'd996,  1'b0, '0, 1'b0},
            '{10'd682,  10'd341,  1'b0, '0, 1'b0},
            '{10'd341,  10'd682,  1'b1, 30'd0, 1'b1},
            '{10'd64,   10'd32,   1'b0, '0, 1'b0}
        };
        errors = 0;
        cycles = 0;
        rx_calm = 1'b0;
        tx_calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        n_total = '0;
        k_chosen = '0;
        out_ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row_want = binom_mod(vectors[i].n, vectors[i].k);
            if (vectors[i].known && row_want !== {vectors[i].value, vectors[i].bad})
            begin
                $display("%0t: table row %0d expected %0d actual %0d", $time, i,
                         vectors[i].value, row_want.value);
                errors++;
            end
            send_pair(vectors[i].n, vectors[i].k);
        end
        in_valid <= 1'b0;
        // hold until every result has drained
        while (pending_binoms.size() != 0)
            @(posedge clk);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            logic [VAL_W-1:0] n;
            logic [VAL_W-1:0] k;
            rx_calm = (i >= 60 && i < 90);
            tx_calm = rx_calm;
            n = VAL_W'($urandom);
            if ($urandom_range(99) < 12)
                k = VAL_W'($urandom);
            else if ($urandom_range(99) < 70)
                k = VAL_W'($urandom_range(32'(n)));
            else
                k = n - VAL_W'($urandom_range(n < 4 ? 32'(n) : 32'd4));
            send_pair(n, k);
        end
        in_valid <= 1'b0;
        rx_calm = 1'b0;
        tx_calm = 1'b0;
        while (pending_binoms.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
